// ===== hw/rtl/i2cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and codes for the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_SEND     = 3'd3,
    CMD_WAIT_ACK = 3'd4,
    CMD_READ     = 3'd5
  } cmd_t;

  typedef enum logic [0:0] {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_LIMIT   = 1'b1
  } reg_idx_t;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
  localparam logic [7:0] ACK_LIMIT_RESET   = 8'd250;
  localparam logic [2:0] BIT_LAST          = 3'd7;

  typedef enum logic [12:0] {
    PH_IDLE       = 13'b0000000000001,
    PH_START_A    = 13'b0000000000010,
    PH_START_B    = 13'b0000000000100,
    PH_STOP_A     = 13'b0000000001000,
    PH_STOP_B     = 13'b0000000010000,
    PH_SEND_DATA  = 13'b0000000100000,
    PH_SEND_HIGH  = 13'b0000001000000,
    PH_SEND_LOW   = 13'b0000010000000,
    PH_ACK_WAIT   = 13'b0000100000000,
    PH_READ_LOW   = 13'b0001000000000,
    PH_READ_HIGH  = 13'b0010000000000,
    PH_RACK_SETUP = 13'b0100000000000,
    PH_RACK_HIGH  = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] half_period;
    logic [7:0] ack_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rdata;
    logic       status;
  } res_t;

endpackage

// ===== hw/rtl/i2cbm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cbm_seq
// Bus sequencer: state registers plus the next-state and result logic for
// one timing tick.
// ----------------------------------------------------------------------------
module i2cbm_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  i2cbm_pkg::cfg_t   cfg,
  input  logic [2:0]        command,
  input  logic [7:0]        data_byte,
  input  logic              send_ack,
  input  logic              sda_in,
  output i2cbm_pkg::res_t   res
);
  import i2cbm_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] delay_count, delay_count_next;
  logic [2:0] bit_counter, bit_counter_next;
  logic [7:0] shift_word, shift_word_next;
  logic [7:0] ack_wait_count, ack_wait_count_next;
  logic [2:0] active_command, active_command_next;
  logic       ack_choice, ack_choice_next;
  logic       scl_reg, scl_reg_next;
  logic       sda_reg, sda_reg_next;
  logic       drive_reg, drive_reg_next;
  logic       status_reg, status_reg_next;
  logic [7:0] read_reg, read_reg_next;
  logic       done;
  logic [7:0] dc_dec;
  logic [7:0] load;

  assign load   = (cfg.half_period == 8'd0) ? 8'd1 : cfg.half_period;
  assign dc_dec = (delay_count != 8'd0) ? delay_count - 8'd1 : 8'd0;

  always_comb begin
    phase_next          = phase;
    delay_count_next    = delay_count;
    bit_counter_next    = bit_counter;
    shift_word_next     = shift_word;
    ack_wait_count_next = ack_wait_count;
    active_command_next = active_command;
    ack_choice_next     = ack_choice;
    scl_reg_next        = scl_reg;
    sda_reg_next        = sda_reg;
    drive_reg_next      = drive_reg;
    status_reg_next     = status_reg;
    read_reg_next       = read_reg;
    done                = 1'b0;
    if (phase == PH_IDLE) begin
      if (command >= CMD_START && command <= CMD_READ) begin
        active_command_next = command;
        status_reg_next     = 1'b0;
        delay_count_next    = load;
      end
      unique case (command)
        CMD_START: begin
          drive_reg_next = 1'b1;
          sda_reg_next   = 1'b1;
          scl_reg_next   = 1'b1;
          phase_next     = PH_START_A;
        end
        CMD_STOP: begin
          drive_reg_next = 1'b1;
          sda_reg_next   = 1'b0;
          scl_reg_next   = 1'b0;
          phase_next     = PH_STOP_A;
        end
        CMD_SEND: begin
          drive_reg_next   = 1'b1;
          scl_reg_next     = 1'b0;
          bit_counter_next = 3'd0;
          shift_word_next  = data_byte;
          sda_reg_next     = data_byte[7];
          phase_next       = PH_SEND_DATA;
        end
        CMD_WAIT_ACK: begin
          drive_reg_next      = 1'b0;
          sda_reg_next        = 1'b1;
          scl_reg_next        = 1'b1;
          ack_wait_count_next = 8'd0;
          phase_next          = PH_ACK_WAIT;
        end
        CMD_READ: begin
          drive_reg_next   = 1'b0;
          sda_reg_next     = 1'b1;
          scl_reg_next     = 1'b0;
          bit_counter_next = 3'd0;
          shift_word_next  = 8'd0;
          ack_choice_next  = send_ack;
          phase_next       = PH_READ_LOW;
        end
        default: begin
        end
      endcase
    end else begin
      delay_count_next = dc_dec;
      if (dc_dec == 8'd0) begin
        unique case (phase)
          PH_START_A: begin
            sda_reg_next     = 1'b0;
            phase_next       = PH_START_B;
            delay_count_next = load;
          end
          PH_START_B: begin
            scl_reg_next = 1'b0;
            done         = 1'b1;
          end
          PH_STOP_A: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_STOP_B;
            delay_count_next = load;
          end
          PH_STOP_B: begin
            sda_reg_next = 1'b1;
            if (active_command == CMD_WAIT_ACK) begin
              status_reg_next = 1'b1;
            end
            done = 1'b1;
          end
          PH_SEND_DATA: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_SEND_HIGH;
            delay_count_next = load;
          end
          PH_SEND_HIGH: begin
            scl_reg_next     = 1'b0;
            phase_next       = PH_SEND_LOW;
            delay_count_next = load;
          end
          PH_SEND_LOW: begin
            if (bit_counter != BIT_LAST) begin
              bit_counter_next = bit_counter + 3'd1;
              shift_word_next  = {shift_word[6:0], 1'b0};
              sda_reg_next     = shift_word[6];
              phase_next       = PH_SEND_DATA;
              delay_count_next = load;
            end else begin
              sda_reg_next = 1'b1;
              done         = 1'b1;
            end
          end
          PH_ACK_WAIT: begin
            if (!sda_in) begin
              scl_reg_next = 1'b0;
              done         = 1'b1;
            end else if (ack_wait_count >= cfg.ack_limit) begin
              // timeout: fall into a stop condition
              drive_reg_next   = 1'b1;
              sda_reg_next     = 1'b0;
              scl_reg_next     = 1'b0;
              phase_next       = PH_STOP_A;
              delay_count_next = load;
            end else begin
              ack_wait_count_next = ack_wait_count + 8'd1;
              delay_count_next    = load;
            end
          end
          PH_READ_LOW: begin
            scl_reg_next     = 1'b1;
            shift_word_next  = {shift_word[6:0], sda_in};
            phase_next       = PH_READ_HIGH;
            delay_count_next = load;
          end
          PH_READ_HIGH: begin
            scl_reg_next     = 1'b0;
            delay_count_next = load;
            if (bit_counter != BIT_LAST) begin
              bit_counter_next = bit_counter + 3'd1;
              phase_next       = PH_READ_LOW;
            end else begin
              drive_reg_next = 1'b1;
              sda_reg_next   = ~ack_choice;
              phase_next     = PH_RACK_SETUP;
            end
          end
          PH_RACK_SETUP: begin
            scl_reg_next     = 1'b1;
            phase_next       = PH_RACK_HIGH;
            delay_count_next = load;
          end
          PH_RACK_HIGH: begin
            scl_reg_next  = 1'b0;
            read_reg_next = shift_word;
            done          = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
        if (done) begin
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      delay_count    <= 8'd0;
      bit_counter    <= 3'd0;
      shift_word     <= 8'd0;
      ack_wait_count <= 8'd0;
      active_command <= CMD_NONE;
      ack_choice     <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      drive_reg      <= 1'b1;
      status_reg     <= 1'b0;
      read_reg       <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      delay_count    <= delay_count_next;
      bit_counter    <= bit_counter_next;
      shift_word     <= shift_word_next;
      ack_wait_count <= ack_wait_count_next;
      active_command <= active_command_next;
      ack_choice     <= ack_choice_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      drive_reg      <= drive_reg_next;
      status_reg     <= status_reg_next;
      read_reg       <= read_reg_next;
    end
  end

  always_comb begin
    res.scl    = scl_reg_next;
    res.sda    = drive_reg_next ? sda_reg_next : 1'b1;
    res.drive  = drive_reg_next;
    res.busy   = (phase_next != PH_IDLE);
    res.done   = done;
    res.rdata  = read_reg_next;
    res.status = status_reg_next;
  end

  a_hold_during_delay: assert property (@(posedge clk) disable iff (rst)
    step && phase != PH_IDLE && delay_count > 8'd1 |-> phase_next == phase)
    else $error("phase moved before its delay ran out");

  a_done_only_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> phase != PH_IDLE)
    else $error("done raised from idle");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(delay_count))
    else $error("state changed without a beat");

endmodule

// ===== hw/rtl/i2c_bit_level_master.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Results: one result beat per input beat, registered and valid in the cycle after acceptance.
// Throughput: one tick per cycle while input is valid and not stalled; the sequencer state updates in one pass.
// A full output register that is stalled holds off the input side.
// Reset: idle, SCL/SDA high and driven, delays 4 ticks, ack limit 250.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] command,
  input  logic [7:0] data_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_drive_enable,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       status
);
  import i2cbm_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic step;

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= HALF_PERIOD_RESET;
      cfg.ack_limit   <= ACK_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period <= cfg_data;
        REG_ACK_LIMIT:   cfg.ack_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  i2cbm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cfg       (cfg),
    .command   (command),
    .data_byte (data_byte),
    .send_ack  (send_ack),
    .sda_in    (sda_in),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign scl_level        = res_q.scl;
  assign sda_level        = res_q.sda;
  assign sda_drive_enable = res_q.drive;
  assign busy_res         = res_q.busy;
  assign done_res         = res_q.done;
  assign read_data        = res_q.rdata;
  assign status           = res_q.status;

  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted beat left no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && busy_res))
    else $error("done and busy together");

  a_released_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sda_drive_enable |-> sda_level)
    else $error("released SDA reported low");

endmodule
